FILE: hw/rtl/iss_pkg.sv
// shared types, command codes and status codes of the indexed sequence store
package iss_pkg;

  // payload field types
  typedef logic [3:0]         cmd_t;
  typedef logic signed [31:0] word_t;
  typedef logic [4:0]         pos_t;
  typedef logic [1:0]         status_t;
  typedef logic [4:0]         count_t;

  // default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // command codes
  localparam cmd_t CMD_PUSH_HEAD = 4'd0;
  localparam cmd_t CMD_PUSH_TAIL = 4'd1;
  localparam cmd_t CMD_POP_HEAD  = 4'd2;
  localparam cmd_t CMD_POP_TAIL  = 4'd3;
  localparam cmd_t CMD_INSERT    = 4'd4;
  localparam cmd_t CMD_REMOVE    = 4'd5;
  localparam cmd_t CMD_PEEK      = 4'd6;
  localparam cmd_t CMD_OVERWRITE = 4'd7;
  localparam cmd_t CMD_CLEAR     = 4'd8;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

FILE: hw/rtl/iss_if.sv
// command and result channel interfaces of the indexed sequence store

interface iss_in_if;
  import iss_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t value_in;
  pos_t  position;
  modport source (output valid, output command, output value_in, output position,
                  input ready);
  modport sink   (input valid, input command, input value_in, input position,
                  output ready);
endinterface

interface iss_out_if;
  import iss_pkg::*;
  logic    valid;
  logic    ready;
  word_t   value_out;
  status_t status;
  count_t  count_out;
  modport source (output valid, output value_out, output status, output count_out,
                  input ready);
  modport sink   (input valid, input value_out, input status, input count_out,
                  output ready);
endinterface

FILE: hw/rtl/indexed_sequence_store.sv
// Indexed sequence store: bounded ordered list of signed values with
// push/pop at either end, indexed insert/remove/peek/overwrite and clear.
// Commands arrive on in_ch (valid/ready); each beat yields exactly one
// result beat on out_ch carrying value_out, status and the new count.
// Entries live in a single-port-write, registered-read memory; one
// small sequencer moves entries through it, a read state then a write
// state for each entry shifted. in_ch is ready only while the sequencer
// is idle, so the next command is taken in the cycle after the result
// is loaded; a new command is never taken before the last one's result
// is loaded.
// A finished result sits in the output register; while out_ch stalls
// the next command is still accepted, and its result waits until the
// held beat has been taken.
// Reset (rst_n low, synchronous) empties the store and drops any held
// result; memory contents are not cleared and need no clearing pass.
module indexed_sequence_store #(
  parameter int CAPACITY   = iss_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = iss_pkg::VALUE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  iss_in_if.sink  in_ch,
  iss_out_if.source out_ch
);
  import iss_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_OPEN_RD  = 4'd2;
  localparam logic [3:0] S_OPEN_WR  = 4'd3;
  localparam logic [3:0] S_PEEK_RD  = 4'd4;
  localparam logic [3:0] S_PEEK_V   = 4'd5;
  localparam logic [3:0] S_CLOSE_RD = 4'd6;
  localparam logic [3:0] S_CLOSE_WR = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [IDX_W-1:0]      at_r, at_nxt;
  logic                  rm_r, rm_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  pos_t                  pos_r, pos_nxt;
  word_t                 res_r, res_nxt;
  status_t               st_r, st_nxt;

  logic                  out_valid_r, out_valid_nxt;
  word_t                 out_value_r, out_value_nxt;
  status_t               out_status_r, out_status_nxt;
  count_t                out_count_r, out_count_nxt;

  // entry memory
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] mem_rdata_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;

  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      pos_x;
  logic                  empty;
  logic                  full;
  word_t                 rd_ext;
  logic [CNT_W-1:0]      ptr_inc;

  assign cnt_x   = CMP_W'(count_r);
  assign pos_x   = CMP_W'(pos_r);
  assign empty   = (count_r == '0);
  assign full    = (count_r == CAP_CNT);
  assign rd_ext  = 32'($signed(mem_rdata_r));
  assign ptr_inc = CNT_W'(ptr_r) + CNT_W'(1);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count_out = out_count_r;

  // memory write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    at_nxt         = at_r;
    rm_nxt         = rm_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = mem_rdata_r;
    mem_raddr      = '0;

    // held result beat leaves
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          val_nxt   = VALUE_BITS'(in_ch.value_in);
          pos_nxt   = in_ch.position;
          res_nxt   = '0;
          st_nxt    = ST_OK;
          rm_nxt    = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              at_nxt    = (cmd_r == CMD_PUSH_HEAD) ? '0 : count_r[IDX_W-1:0];
              ptr_nxt   = count_r[IDX_W-1:0];
              state_nxt = S_OPEN_RD;
            end
          end
          CMD_POP_HEAD, CMD_POP_TAIL: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              at_nxt    = (cmd_r == CMD_POP_HEAD) ? '0 : (count_r[IDX_W-1:0] - IDX_W'(1));
              rm_nxt    = 1'b1;
              state_nxt = S_PEEK_RD;
            end
          end
          CMD_INSERT: begin
            if (pos_x > cnt_x) begin
              st_nxt = ST_RANGE;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else begin
              at_nxt    = pos_x[IDX_W-1:0];
              ptr_nxt   = count_r[IDX_W-1:0];
              state_nxt = S_OPEN_RD;
            end
          end
          CMD_REMOVE, CMD_PEEK, CMD_OVERWRITE: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              st_nxt = ST_RANGE;
            end else if (cmd_r == CMD_OVERWRITE) begin
              mem_we    = 1'b1;
              mem_waddr = pos_x[IDX_W-1:0];
              mem_wdata = val_r;
            end else begin
              at_nxt    = pos_x[IDX_W-1:0];
              rm_nxt    = (cmd_r == CMD_REMOVE);
              state_nxt = S_PEEK_RD;
            end
          end
          CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      // open a gap: move entries up one slot from the tail down to at
      S_OPEN_RD: begin
        if (ptr_r == at_r) begin
          mem_we    = 1'b1;
          mem_waddr = at_r;
          mem_wdata = val_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = ptr_r - IDX_W'(1);
          state_nxt = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata_r;
        ptr_nxt   = ptr_r - IDX_W'(1);
        state_nxt = S_OPEN_RD;
      end
      // read the addressed entry
      S_PEEK_RD: begin
        mem_raddr = at_r;
        state_nxt = S_PEEK_V;
      end
      S_PEEK_V: begin
        res_nxt   = rd_ext;
        ptr_nxt   = at_r;
        state_nxt = rm_r ? S_CLOSE_RD : S_DONE;
      end
      // close the gap: move entries down one slot toward at
      S_CLOSE_RD: begin
        if (ptr_inc >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = ptr_inc[IDX_W-1:0];
          state_nxt = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata_r;
        ptr_nxt   = ptr_inc[IDX_W-1:0];
        state_nxt = S_CLOSE_RD;
      end
      // load result beat once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = st_r;
          out_count_nxt  = cnt_x[4:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    at_r         <= at_nxt;
    rm_r         <= rm_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
